### hdl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants for the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int PW = 32;  // pressure width
  localparam int VW = 40;  // value width

  // configuration register indexes
  localparam logic CFG_OFFSET = 1'b0;
  localparam logic CFG_POINTS = 1'b1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // front to back command: a table write or a query with its saturated pressure
  typedef struct packed {
    opcode_t              op;
    logic [5:0]           index;
    logic [PW-1:0]        pressure;
    logic signed [VW-1:0] value;
  } query_cmd_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [5:0]           segment;
    logic                 oor;
    logic                 zw;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SRCH_RD,
    B_SRCH_CMP,
    B_FETCH0,
    B_FETCH1,
    B_FETCH2,
    B_MUL,
    B_MUL_HI,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

### hdl/tli_front.sv
// ----------------------------------------------------------------------------
// tli_front
// Accepts items, applies the offset with saturation and queues commands.
// ----------------------------------------------------------------------------
module tli_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   op,
  input  logic [5:0]             point_index,
  input  logic [31:0]            point_pressure,
  input  logic signed [39:0]     point_value,
  input  logic signed [31:0]     query_pressure,
  input  logic [31:0]            pressure_offset,
  output logic                   in_ready,
  output logic                   q_valid,
  output tli_pkg::query_cmd_t    q_cmd,
  input  logic                   q_take
);
  import tli_pkg::*;

  query_cmd_t  slot [2];
  logic [1:0]  cnt;
  logic        wp, rp;
  logic [33:0] sum;
  logic [31:0] sat;
  logic        push_q;

  assign sum = {{2{query_pressure[31]}}, query_pressure} + {2'b00, pressure_offset};
  always_comb begin
    priority if (sum[33]) sat = '0;
    else if (sum[32]) sat = '1;
    else sat = sum[31:0];
  end

  assign in_ready = (cnt != 2'd2);
  // writes share the queue so they land in order with queries
  assign push_q   = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = slot[rp];

  always_ff @(posedge clk) begin
    if (push_q) begin
      slot[wp] <= '{op: opcode_t'(op), index: point_index,
                    pressure: (op == OP_QUERY) ? sat : point_pressure,
                    value: point_value};
    end
    if (rst) begin
      cnt <= '0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (push_q) wp <= ~wp;
      if (q_take && q_valid) rp <= ~rp;
      cnt <= cnt + {1'b0, push_q} - {1'b0, q_take && q_valid};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("front queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("take from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (push_q && !q_take) |=> cnt == $past(cnt) + 2'd1) else $error("count slip");
endmodule

### hdl/tli_divider.sv
// ----------------------------------------------------------------------------
// tli_divider
// Restoring divider, one quotient bit per cycle, 74-bit dividend.
// ----------------------------------------------------------------------------
module tli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [73:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [73:0] quotient
);
  import tli_pkg::*;

  logic [31:0] rem;
  logic [73:0] num;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, num[73]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 7'd0; rem <= '0; num <= dividend;
      end else if (busy) begin
        // partial remainder stays below the divisor, so 32 bits hold it
        if (trial[32]) rem <= {rem[30:0], num[73]};
        else rem <= trial[31:0];
        num <= {num[72:0], ~trial[32]};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd73) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
  assign quotient = num;
endmodule

### hdl/tli_back.sv
// ----------------------------------------------------------------------------
// tli_back
// Holds the table, applies writes in order, searches one segment at a time
// (read, then compare), interpolates, and keeps a one-entry result register.
// ----------------------------------------------------------------------------
module tli_back #(
  parameter int TABLE_POINTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [6:0]             points_in_use,
  input  logic                   q_valid,
  input  tli_pkg::query_cmd_t    q_cmd,
  output logic                   q_take,
  output logic                   res_valid,
  output tli_pkg::result_t       res,
  input  logic                   res_take
);
  import tli_pkg::*;
  localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;

  logic [31:0]        bp_mem [TABLE_POINTS];
  logic signed [39:0] val_mem [TABLE_POINTS];
  logic [31:0]        bp_rd;
  logic signed [39:0] val_rd;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;

  back_state_t state, state_next;
  logic [AW:0]   idx, nlim;
  logic [31:0]   p, xa, xb;
  logic signed [39:0] v0;
  logic          oor;
  logic [AW-1:0] seg;
  logic [40:0]   mdv;
  logic [31:0]   mdp;
  logic [31:0]   mdx;
  logic          neg;
  logic [73:0]   prod, prod_full;
  logic          div_start, div_done;
  logic [73:0]   quo;
  logic [41:0]   qcap;
  logic signed [42:0] sumv;
  logic signed [40:0] dv;

  assign mem_we = (state == B_IDLE) && q_valid && (q_cmd.op == OP_WRITE) &&
                  (32'(q_cmd.index) < TABLE_POINTS);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bp_mem[AW'(q_cmd.index)]  <= q_cmd.pressure;
      val_mem[AW'(q_cmd.index)] <= q_cmd.value;
    end
    bp_rd  <= bp_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
  end

  always_comb begin
    if (points_in_use < 7'd2) nlim = (AW+1)'(2);
    else if (32'(points_in_use) > TABLE_POINTS) nlim = (AW+1)'(TABLE_POINTS);
    else nlim = (AW+1)'(points_in_use);
  end

  // read address follows the search index; fetch phases use seg
  always_comb begin
    unique case (state)
      B_FETCH0: rd_addr = seg;
      B_FETCH1: rd_addr = seg + AW'(1);
      default:  rd_addr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && (q_cmd.op == OP_QUERY) && !res_valid) state_next = B_SRCH_RD;
      end
      B_SRCH_RD:  state_next = B_SRCH_CMP;
      B_SRCH_CMP: begin
        if (idx != '0 && p >= xa && p <= bp_rd) state_next = B_FETCH0;
        else if (idx + 1'b1 >= nlim) state_next = B_FETCH0;
        else state_next = B_SRCH_RD;
      end
      B_FETCH0:   state_next = B_FETCH1;
      B_FETCH1:   state_next = B_FETCH2;
      B_FETCH2:   state_next = (xb == bp_rd) ? B_DONE : B_MUL;
      B_MUL:      state_next = B_MUL_HI;
      B_MUL_HI:   state_next = B_DIV;
      B_DIV:      if (div_done) state_next = B_DONE;
      B_DONE:     state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  // a write needs no result slot, so only queries wait on the result register
  assign q_take    = (state == B_IDLE) && q_valid &&
                     ((q_cmd.op == OP_WRITE) || !res_valid);
  assign div_start = (state == B_MUL_HI);

  // dv from the upper value as it lands from the table
  assign dv = 41'(val_rd) - 41'(v0);

  // product plus half divisor for rounding: a low part registered in B_MUL plus a high part added here
  assign prod_full = prod + {1'b0, 41'(mdv[40:32]) * 41'(mdp), 32'b0};

  tli_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod_full),
    .divisor(mdx), .done(div_done), .quotient(quo)
  );

  assign qcap = (quo > 74'(42'h200_0000_0000)) ? 42'h200_0000_0000 : quo[41:0];
  assign sumv = neg ? (43'(v0) - 43'(qcap)) : (43'(v0) + 43'(qcap));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE; res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_take) res_valid <= 1'b0;
      if (state == B_DONE) res_valid <= 1'b1;
    end
    unique case (state)
      B_IDLE: begin
        p <= q_cmd.pressure; idx <= '0; oor <= 1'b1; seg <= '0;
      end
      B_SRCH_CMP: begin
        xa <= bp_rd;
        if (idx != '0 && p >= xa && p <= bp_rd) begin
          oor <= 1'b0; seg <= AW'(idx - 1'b1);
        end
        idx <= idx + 1'b1;
      end
      B_FETCH1: begin xb <= bp_rd; v0 <= val_rd; end
      B_FETCH2: begin
        // ends known: hold lower value for a flat segment
        res.zw <= (xb == bp_rd);
        mdx <= (bp_rd >= xb) ? bp_rd - xb : xb - bp_rd;
        mdp <= (p >= xb) ? p - xb : xb - p;
        mdv <= dv[40] ? 41'(-dv) : dv;
        neg <= dv[40] ^ (p < xb) ^ (bp_rd < xb);
      end
      B_MUL: prod <= 74'(64'(mdv[31:0]) * 64'(mdp) + 64'(mdx >> 1));
      B_MUL_HI: ;
      B_DIV: ;
      B_DONE: begin
        res.segment <= 6'(seg);
        res.oor     <= oor;
        if (res.zw) res.value <= v0;
        else if (sumv > 43'sd549755813887) res.value <= 40'sh7F_FFFF_FFFF;
        else if (sumv < -43'sd549755813888) res.value <= 40'sh80_0000_0000;
        else res.value <= sumv[39:0];
      end
      default: ;
    endcase
  end
endmodule

### hdl/table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_core
// Piecewise linear table interpolator with a queue-style interface.
// ----------------------------------------------------------------------------
// Writes and queries pass in order through a two-entry queue to the back end;
// a write is applied by the back end while idle. A query starts, searches the
// segments one at a time, fetches its operands, runs the split multiply and
// the bit-serial 74-bit divide and then loads the result; a zero-width
// segment skips the multiply and divide. A new query starts only after the
// previous result has been popped. The table memory is undefined until
// written; no clearing pass runs after reset.
module table_linear_interpolator_core #(
  parameter int TABLE_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [5:0]         point_index,
  input  logic [31:0]        point_pressure,
  input  logic signed [39:0] point_value,
  input  logic signed [31:0] query_pressure,
  output logic               empty,
  input  logic               pop,
  output logic signed [39:0] interpolated_value,
  output logic [5:0]         segment_index,
  output logic               out_of_range,
  output logic               zero_width,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import tli_pkg::*;

  logic [31:0] pressure_offset;
  logic [6:0]  points_in_use;
  logic        in_ready, q_valid, q_take, res_valid;
  query_cmd_t  q_cmd;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_offset <= '0; points_in_use <= 7'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OFFSET) pressure_offset <= cfg_data;
      else points_in_use <= cfg_data[6:0];
    end
  end

  assign full = !in_ready;

  tli_front u_front (
    .clk(clk), .rst(rst), .in_valid(push), .op(opcode),
    .point_index(point_index), .point_pressure(point_pressure),
    .point_value(point_value),
    .query_pressure(query_pressure), .pressure_offset(pressure_offset),
    .in_ready(in_ready), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  tli_back #(.TABLE_POINTS(TABLE_POINTS)) u_back (
    .clk(clk), .rst(rst),
    .points_in_use(points_in_use), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_take(q_take), .res_valid(res_valid), .res(res), .res_take(pop && res_valid)
  );

  assign empty              = !res_valid;
  assign interpolated_value = res.value;
  assign segment_index      = res.segment;
  assign out_of_range       = res.oor;
  assign zero_width         = res.zw;
endmodule

### tb/sv/table_linear_interpolator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_linear_interpolator_core_test
// Self-checking bench for the table interpolator: loads breakpoint tables,
// issues queries under random idling and a long output hold-off, and checks
// every result against an in-bench prediction of the interpolation.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core_test;
  import tli_pkg::*;

  localparam int   NPTS       = 64;
  localparam int   DRAIN      = 300;
  localparam int   WDOG_LIMIT = 20000;
  localparam int   HOLD_LEN   = 3000;
  localparam longint VMAX     = 64'sd549755813887;
  localparam longint VMIN     = -64'sd549755813888;

  typedef struct {
    opcode_t            op;
    logic [5:0]         idx;
    logic [31:0]        pr;
    logic signed [39:0] val;
    logic signed [31:0] qp;
  } req_t;

  logic               clk, rst, push, full, empty, pop;
  logic               opcode;
  logic [5:0]         point_index, segment_index;
  logic [31:0]        point_pressure, cfg_data;
  logic signed [39:0] point_value, interpolated_value;
  logic signed [31:0] query_pressure;
  logic               out_of_range, zero_width, cfg_we, cfg_index;

  table_linear_interpolator_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .point_index(point_index), .point_pressure(point_pressure),
    .point_value(point_value), .query_pressure(query_pressure),
    .empty(empty), .pop(pop), .interpolated_value(interpolated_value),
    .segment_index(segment_index), .out_of_range(out_of_range),
    .zero_width(zero_width), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // table as the block should hold it, updated on transfer
  logic [31:0]        bp_tbl [NPTS];
  logic signed [39:0] val_tbl [NPTS];
  logic [31:0]        offset_reg;
  logic [6:0]         points_reg;
  // generator's view of the table, updated when items are queued
  logic [31:0]        gen_bp [NPTS];

  req_t    pend_q [$];
  result_t interp_q [$];
  int      err_cnt = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  bit      calm = 0;
  bit      held = 0;
  int      hold_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic result_t interpolate(logic signed [31:0] qp);
    result_t r;
    longint p, x0, x1, v0, v1, dv, dp, dx, res;
    longint unsigned mdv, mdp, mdx;
    logic [127:0] prod, q;
    int n, seg;
    bit oor, neg, zw;
    p = longint'(qp) + longint'({32'b0, offset_reg});
    if (p < 0) p = 0;
    if (p > 64'sh0FFFF_FFFF) p = 64'sh0FFFF_FFFF;
    n = points_reg;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    seg = 0;
    oor = 1;
    for (int i = 0; i + 1 < n; i++)
      if (oor && p >= longint'({32'b0, bp_tbl[i]}) && p <= longint'({32'b0, bp_tbl[i+1]})) begin
        seg = i;
        oor = 0;
      end
    x0 = longint'({32'b0, bp_tbl[seg]});
    x1 = longint'({32'b0, bp_tbl[seg+1]});
    v0 = longint'(val_tbl[seg]);
    v1 = longint'(val_tbl[seg+1]);
    zw = (x0 == x1);
    if (zw) begin
      res = v0;
    end else begin
      dv = v1 - v0;
      dp = p - x0;
      dx = x1 - x0;
      neg = (dv < 0) != (dp < 0);
      if (dx < 0) neg = !neg;
      mdv = (dv < 0) ? -dv : dv;
      mdp = (dp < 0) ? -dp : dp;
      mdx = (dx < 0) ? -dx : dx;
      prod = 128'(mdv) * 128'(mdp) + 128'(mdx >> 1);
      q = prod / 128'(mdx);
      if (q > (128'd1 << 41)) q = 128'd1 << 41;
      res = neg ? v0 - longint'(q[63:0]) : v0 + longint'(q[63:0]);
      if (res > VMAX) res = VMAX;
      if (res < VMIN) res = VMIN;
    end
    r.value   = res[39:0];
    r.segment = seg[5:0];
    r.oor     = oor;
    r.zw      = zw;
    return r;
  endfunction

  // driver: hold an offered item until it transfers
  always @(posedge clk) begin
    bit taken, keep;
    req_t it;
    if (rst) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (taken) begin
        it = pend_q.pop_front();
        if (it.op == OP_WRITE) begin
          bp_tbl[it.idx]  = it.pr;
          val_tbl[it.idx] = it.val;
        end else begin
          interp_q.push_back(interpolate(it.qp));
        end
      end
      keep = push && !taken;
      if (pend_q.size() > 0 && (keep || calm || $urandom_range(99) >= 23)) begin
        push           <= 1'b1;
        opcode         <= pend_q[0].op;
        point_index    <= pend_q[0].idx;
        point_pressure <= pend_q[0].pr;
        point_value    <= pend_q[0].val;
        query_pressure <= pend_q[0].qp;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (interp_q.size() == 0) begin
          $error("result with nothing expected");
          err_cnt++;
        end else begin
          e = interp_q.pop_front();
          if (interpolated_value !== e.value) begin
            $error("interpolated_value exp %0d got %0d", e.value, interpolated_value);
            err_cnt++;
          end
          if (segment_index !== e.segment) begin
            $error("segment_index exp %0d got %0d", e.segment, segment_index);
            err_cnt++;
          end
          if (out_of_range !== e.oor) begin
            $error("out_of_range exp %0b got %0b", e.oor, out_of_range);
            err_cnt++;
          end
          if (zero_width !== e.zw) begin
            $error("zero_width exp %0b got %0b", e.zw, zero_width);
            err_cnt++;
          end
        end
      end
      if (!held && results_seen == 150) begin
        held = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || $urandom_range(99) >= 23;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OFFSET) offset_reg = data;
    else points_reg = data[6:0];
  endtask

  task automatic set_config(logic [31:0] off, logic [6:0] pts);
    cfg_write(CFG_OFFSET, off);
    cfg_write(CFG_POINTS, {25'($urandom_range(33554431, 0)), pts});
  endtask

  task automatic add_write(int idx, logic [31:0] pr, logic signed [39:0] v);
    req_t it;
    it.op  = OP_WRITE;
    it.idx = idx[5:0];
    it.pr  = pr;
    it.val = v;
    it.qp  = $urandom;
    gen_bp[idx] = pr;
    pend_q.push_back(it);
  endtask

  task automatic add_query(logic signed [31:0] qp);
    req_t it;
    it.op  = OP_QUERY;
    it.idx = 6'($urandom);
    it.pr  = $urandom;
    it.val = 40'({$urandom, $urandom});
    it.qp  = qp;
    pend_q.push_back(it);
  endtask

  function automatic logic signed [39:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(2) == 0) return r[39:0];
    return {{20{r[19]}}, r[19:0]};
  endfunction

  // kind 0 ascending, 1 unsorted, 2 descending
  task automatic load_table(int kind);
    longint b;
    b = (kind == 2) ? 64'd4294967295 - $urandom_range(65535) : $urandom_range(32'h7FFF_FFFF);
    for (int i = 0; i < NPTS; i++) begin
      if (kind == 1) add_write(i, $urandom, rand_value());
      else add_write(i, b[31:0], rand_value());
      if ($urandom_range(9) != 0) begin
        if (kind == 2) b -= $urandom_range(1 << 25);
        else b += $urandom_range(1 << 25);
      end
    end
  endtask

  // aim most queries into a segment or at a breakpoint
  task automatic add_rand_query();
    longint p, lo, hi, d;
    longint unsigned r64;
    int n, i, m;
    n = points_reg < 2 ? 2 : (points_reg > NPTS ? NPTS : points_reg);
    m = $urandom_range(99);
    i = $urandom_range(n - 2);
    lo = gen_bp[i] < gen_bp[i+1] ? gen_bp[i] : gen_bp[i+1];
    hi = gen_bp[i] < gen_bp[i+1] ? gen_bp[i+1] : gen_bp[i];
    r64 = {$urandom, $urandom};
    if (m < 60) p = lo + longint'(r64 % longint'(hi - lo + 1));
    else p = gen_bp[$urandom_range(n - 1)];
    d = p - longint'({32'b0, offset_reg});
    if (m < 80 && d >= -64'sd2147483648 && d <= 64'sd2147483647) add_query(d[31:0]);
    else add_query($urandom);
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || push || interp_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_phase(int kind, logic [31:0] off, logic [6:0] pts, int nq);
    drain();
    set_config(off, pts);
    load_table(kind);
    for (int k = 0; k < nq; k++) begin
      if ($urandom_range(9) == 0) add_write($urandom_range(NPTS - 1), $urandom, rand_value());
      add_rand_query();
    end
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    pop       = 1'b0;
    opcode    = OP_WRITE;
    point_index = '0;
    point_pressure = '0;
    point_value = '0;
    query_pressure = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_OFFSET;
    cfg_data  = '0;
    offset_reg = '0;
    points_reg = 7'd2;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: ascending table with a zero-width first segment
    set_config(32'd0, 7'd64);
    for (int i = 0; i < NPTS; i++)
      add_write(i, (i == 1) ? 32'd4096 : 4096 * (i + 1), (i % 2) ? VMAX[39:0] : VMIN[39:0]);
    add_query(32'sh8000_0000);
    add_query(32'sh7FFF_FFFF);
    add_query(32'sd0);
    add_query(32'sd4096);
    add_query(32'sd8192);
    add_query(32'sd10000);
    add_query(32'sd4096 * 63);
    add_query(32'sd4096 * 64);
    add_query(32'sd4096 * 64 - 1);
    add_query(32'sd4096 * 64 + 1);

    // steep segment: saturate the summed pressure high and the value both ways
    drain();
    set_config(32'hFFFF_FFFF, 7'd2);
    add_write(0, 32'd1000, 40'sd0);
    add_write(1, 32'd1001, VMAX[39:0]);
    add_query(32'sh7FFF_FFFF);
    add_query(32'sh8000_0000);
    add_write(1, 32'd1001, VMIN[39:0]);
    add_query(32'sd5);
    add_write(0, 32'd1001, 40'sd7);
    add_write(1, 32'd1000, -40'sd9);
    add_query(32'sd0);
    add_query(32'sh8000_0000);

    calm = 1;
    random_phase(0, 32'd0, 7'd64, 120);
    drain();
    calm = 0;
    random_phase(1, $urandom, 7'd0, 120);
    random_phase(2, $urandom, 7'd127, 120);
    random_phase(0, $urandom_range(1 << 20), 7'($urandom_range(64, 2)), 140);
    random_phase(1, 32'hFFFF_FFFF, 7'd64, 90);
    random_phase(0, $urandom, 7'($urandom_range(127)), 120);
    random_phase(0, 32'd0, 7'd1, 90);
    drain();
    if (err_cnt == 0 && interp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
